// ===== src/svs_pkg.sv =====
package svs_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 24;
  localparam int SUM_W       = SAMPLE_W + ADDR_W;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int SS_W        = 2 * SAMPLE_W + ADDR_W + 1;
  localparam int DIV_CNT_W   = $clog2(SS_W + 1);
  localparam int PV_W        = 49;
  localparam int SV_W        = 50;
  localparam int SD_W        = 25;
  localparam int RAD_W       = SV_W + 1;
  localparam int SQRT_CNT_W  = $clog2(SD_W + 1);

  // one closed run handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sum;
    logic                    drop;
  } job_t;

endpackage

// ===== src/svs_front.sv =====
module svs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [svs_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_last,
  input  logic                                 back_busy,
  output logic                                 job_valid,
  output svs_pkg::job_t                        job,
  input  logic                                 job_pop,
  input  logic [svs_pkg::ADDR_W-1:0]           rd_addr,
  output logic signed [svs_pkg::SAMPLE_W-1:0]  rd_data
);

  logic signed [svs_pkg::SAMPLE_W-1:0] mem [svs_pkg::MAX_SAMPLES];
  logic [svs_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [svs_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                                drop_r, drop_nxt;
  logic                                q_v_r;
  svs_pkg::job_t                       q_r;
  logic signed [svs_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                                acc, room;

  // store is shared with the back pass, so hold off while a run is queued or the back end is busy
  assign in_stall  = q_v_r | back_busy;
  assign acc       = in_valid & ~in_stall;
  assign room      = cnt_r < svs_pkg::CNT_W'(svs_pkg::MAX_SAMPLES);
  assign job_valid = q_v_r;
  assign job       = q_r;
  assign rd_data   = rd_data_r;

  // next run totals
  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    drop_nxt = drop_r;
    if (room) begin
      cnt_nxt = cnt_r + 1'b1;
      sum_nxt = sum_r + svs_pkg::SUM_W'(in_sample);
    end else begin
      drop_nxt = 1'b1;
    end
  end

  // run registers and job queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      drop_r <= 1'b0;
      q_v_r  <= 1'b0;
    end else begin
      if (job_pop) begin
        q_v_r <= 1'b0;
      end
      if (acc) begin
        if (in_last) begin
          cnt_r    <= '0;
          sum_r    <= '0;
          drop_r   <= 1'b0;
          q_v_r    <= 1'b1;
          q_r.n    <= cnt_nxt;
          q_r.sum  <= sum_nxt;
          q_r.drop <= drop_nxt;
        end else begin
          cnt_r  <= cnt_nxt;
          sum_r  <= sum_nxt;
          drop_r <= drop_nxt;
        end
      end
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (acc && room) begin
      mem[cnt_r[svs_pkg::ADDR_W-1:0]] <= in_sample;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== src/svs_div.sv =====
module svs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [svs_pkg::SS_W-1:0]      dividend,
  input  logic [svs_pkg::CNT_W-1:0]     divisor,
  output logic                          done,
  output logic [svs_pkg::SS_W-1:0]      quotient
);

  logic [svs_pkg::SS_W-1:0]      q_r;
  logic [svs_pkg::CNT_W-1:0]     d_r;
  logic [svs_pkg::CNT_W-1:0]     rem_r;
  logic [svs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          run_r, done_r;
  logic [svs_pkg::CNT_W:0]       trial;
  logic                          ge;

  assign trial    = {rem_r, q_r[svs_pkg::SS_W-1]};
  assign ge       = trial >= {1'b0, d_r};
  assign done     = done_r;
  assign quotient = q_r;

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= dividend;
        d_r   <= divisor;
        rem_r <= '0;
        cnt_r <= svs_pkg::DIV_CNT_W'(svs_pkg::SS_W);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? svs_pkg::CNT_W'(trial - {1'b0, d_r})
                    : trial[svs_pkg::CNT_W-1:0];
        q_r   <= {q_r[svs_pkg::SS_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == svs_pkg::DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/svs_sqrt.sv =====
module svs_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [svs_pkg::SV_W-1:0]   radicand,
  output logic                       done,
  output logic [svs_pkg::SD_W-1:0]   root
);

  logic [svs_pkg::RAD_W-1:0]      x_r, res_r, bit_r, trial;
  logic [svs_pkg::SQRT_CNT_W-1:0] cnt_r;
  logic                           run_r, done_r;

  assign trial = res_r + bit_r;
  assign done  = done_r;
  assign root  = res_r[svs_pkg::SD_W-1:0];

  // bit-pair square root, one result bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r   <= svs_pkg::RAD_W'(radicand);
        res_r <= '0;
        bit_r <= svs_pkg::RAD_W'(1) << (2 * (svs_pkg::SD_W - 1));
        cnt_r <= svs_pkg::SQRT_CNT_W'(svs_pkg::SD_W);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == svs_pkg::SQRT_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/svs_back.sv =====
module svs_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 job_valid,
  input  svs_pkg::job_t                        job,
  output logic                                 job_pop,
  output logic                                 busy,
  output logic [svs_pkg::ADDR_W-1:0]           rd_addr,
  input  logic signed [svs_pkg::SAMPLE_W-1:0]  rd_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [svs_pkg::CNT_W-1:0]            out_count,
  output logic signed [svs_pkg::SUM_W-1:0]     out_total,
  output logic signed [svs_pkg::SAMPLE_W-1:0]  out_mean,
  output logic [svs_pkg::PV_W-1:0]             out_pop_variance,
  output logic [svs_pkg::SD_W-1:0]             out_pop_std_dev,
  output logic [svs_pkg::SV_W-1:0]             out_sample_variance,
  output logic [svs_pkg::SD_W-1:0]             out_sample_std_dev,
  output logic                                 out_sample_undefined,
  output logic                                 out_overflowed
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MEAN = 3'd1;
  localparam logic [2:0] ST_PASS = 3'd2;
  localparam logic [2:0] ST_DIVP = 3'd3;
  localparam logic [2:0] ST_DIVS = 3'd4;
  localparam logic [2:0] ST_SQP  = 3'd5;
  localparam logic [2:0] ST_SQS  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]                          st_r;
  svs_pkg::job_t                       job_r;
  logic signed [svs_pkg::SAMPLE_W-1:0] mean_r;
  logic [svs_pkg::SS_W-1:0]            ss_r;
  logic [svs_pkg::SQ_W-1:0]            sq_r;
  logic [svs_pkg::CNT_W-1:0]           addr_r;
  logic                                v1_r, v2_r;
  logic [svs_pkg::PV_W-1:0]            pv_r;
  logic [svs_pkg::SV_W-1:0]            sv_r;
  logic [svs_pkg::SD_W-1:0]            psd_r, ssd_r;
  logic                                ov_r;
  logic                                one;
  logic                                issue, pass_end, load;
  logic signed [svs_pkg::DIFF_W-1:0]   diff;
  logic [svs_pkg::DIFF_W-1:0]          mag;
  logic [svs_pkg::SUM_W-1:0]           sum_mag;
  logic                                div_start, div_done, sq_start, sq_done;
  logic [svs_pkg::SS_W-1:0]            div_a, div_q;
  logic [svs_pkg::CNT_W-1:0]           div_b;
  logic [svs_pkg::SV_W-1:0]            sq_x;
  logic [svs_pkg::SD_W-1:0]            sq_root;
  logic signed [svs_pkg::SUM_W-1:0]    q_signed;

  assign one      = job_r.n == svs_pkg::CNT_W'(1);
  assign busy     = st_r != ST_IDLE;
  assign job_pop  = (st_r == ST_IDLE) & job_valid;
  assign issue    = (st_r == ST_PASS) & (addr_r < job_r.n);
  assign pass_end = (st_r == ST_PASS) & ~issue & ~v1_r & ~v2_r;
  assign load     = (st_r == ST_DONE) & (~ov_r | ~out_stall);
  assign rd_addr  = addr_r[svs_pkg::ADDR_W-1:0];
  assign sum_mag  = job.sum[svs_pkg::SUM_W-1] ? svs_pkg::SUM_W'(-job.sum)
                                              : svs_pkg::SUM_W'(job.sum);
  assign diff     = svs_pkg::DIFF_W'(rd_data) - svs_pkg::DIFF_W'(mean_r);
  assign mag      = diff[svs_pkg::DIFF_W-1] ? svs_pkg::DIFF_W'(-diff)
                                            : svs_pkg::DIFF_W'(diff);
  assign q_signed = job_r.sum[svs_pkg::SUM_W-1]
                    ? -svs_pkg::SUM_W'(div_q) : svs_pkg::SUM_W'(div_q);
  assign out_valid = ov_r;

  // launch of the shared divider and root units
  always_comb begin
    div_start = 1'b0;
    div_a     = svs_pkg::SS_W'(sum_mag);
    div_b     = job.n;
    sq_start  = 1'b0;
    sq_x      = svs_pkg::SV_W'(pv_r);
    case (st_r)
      ST_IDLE: begin
        div_start = job_valid;
      end
      ST_PASS: begin
        div_start = pass_end;
        div_a     = ss_r;
        div_b     = job_r.n;
      end
      ST_DIVP: begin
        div_start = div_done & ~one;
        div_a     = ss_r;
        div_b     = job_r.n - 1'b1;
        sq_start  = div_done & one;
        sq_x      = svs_pkg::SV_W'(div_q[svs_pkg::PV_W-1:0]);
      end
      ST_DIVS: begin
        sq_start = div_done;
      end
      ST_SQP: begin
        sq_start = sq_done & ~one;
        sq_x     = sv_r;
      end
      default: begin
      end
    endcase
  end

  svs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  svs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_x),
    .done     (sq_done),
    .root     (sq_root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      // result register valid: a new load wins over the drain
      if (load) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      case (st_r)
        ST_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            st_r  <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            mean_r <= q_signed[svs_pkg::SAMPLE_W-1:0];
            addr_r <= '0;
            st_r   <= ST_PASS;
          end
        end
        ST_PASS: begin
          if (issue) begin
            addr_r <= addr_r + 1'b1;
          end
          if (pass_end) begin
            st_r <= ST_DIVP;
          end
        end
        ST_DIVP: begin
          if (div_done) begin
            pv_r <= div_q[svs_pkg::PV_W-1:0];
            sv_r <= '0;
            st_r <= one ? ST_SQP : ST_DIVS;
          end
        end
        ST_DIVS: begin
          if (div_done) begin
            sv_r <= div_q[svs_pkg::SV_W-1:0];
            st_r <= ST_SQP;
          end
        end
        ST_SQP: begin
          if (sq_done) begin
            psd_r <= sq_root;
            ssd_r <= '0;
            st_r  <= one ? ST_DONE : ST_SQS;
          end
        end
        ST_SQS: begin
          if (sq_done) begin
            ssd_r <= sq_root;
            st_r  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  // squared deviation pipeline: read, square, accumulate
  always_ff @(posedge clk) begin
    if (v1_r) begin
      sq_r <= mag * mag;
    end
    if (st_r == ST_MEAN) begin
      ss_r <= '0;
    end else if (v2_r) begin
      ss_r <= ss_r + svs_pkg::SS_W'(sq_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_count            <= job_r.n;
      out_total            <= job_r.sum;
      out_mean             <= mean_r;
      out_pop_variance     <= pv_r;
      out_pop_std_dev      <= psd_r;
      out_sample_variance  <= sv_r;
      out_sample_std_dev   <= ssd_r;
      out_sample_undefined <= one;
      out_overflowed       <= job_r.drop;
    end
  end

endmodule

// ===== src/sample_variance_stddev_unit.sv =====
// channel  direction  handshake           payload
// in_      input      in_valid/in_stall   sample, last
// out_     output     out_valid/out_stall count, total, mean, variances, std devs, flags
//
// samples load one per cycle into a 1024-entry store while no run is pending.
// after a request marked last the back end runs three divides, a squared-deviation
// pass over the store and two roots; a one-sample run skips one divide and one root.
// input stalls from the last request until the back end has loaded its result, which
// waits while the output register is still held.
// synchronous active-low reset clears run totals, the job queue and the sequencer.
module sample_variance_stddev_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [svs_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [svs_pkg::CNT_W-1:0]            out_count,
  output logic signed [svs_pkg::SUM_W-1:0]     out_total,
  output logic signed [svs_pkg::SAMPLE_W-1:0]  out_mean,
  output logic [svs_pkg::PV_W-1:0]             out_pop_variance,
  output logic [svs_pkg::SD_W-1:0]             out_pop_std_dev,
  output logic [svs_pkg::SV_W-1:0]             out_sample_variance,
  output logic [svs_pkg::SD_W-1:0]             out_sample_std_dev,
  output logic                                 out_sample_undefined,
  output logic                                 out_overflowed
);

  logic                                job_valid, job_pop, back_busy;
  svs_pkg::job_t                       job;
  logic [svs_pkg::ADDR_W-1:0]          rd_addr;
  logic signed [svs_pkg::SAMPLE_W-1:0] rd_data;

  svs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .in_last   (in_last),
    .back_busy (back_busy),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  svs_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .job_valid            (job_valid),
    .job                  (job),
    .job_pop              (job_pop),
    .busy                 (back_busy),
    .rd_addr              (rd_addr),
    .rd_data              (rd_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_count            (out_count),
    .out_total            (out_total),
    .out_mean             (out_mean),
    .out_pop_variance     (out_pop_variance),
    .out_pop_std_dev      (out_pop_std_dev),
    .out_sample_variance  (out_sample_variance),
    .out_sample_std_dev   (out_sample_std_dev),
    .out_sample_undefined (out_sample_undefined),
    .out_overflowed       (out_overflowed)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // one set of run statistics at port widths
  typedef struct {
    logic [svs_pkg::CNT_W-1:0]    count;
    logic [svs_pkg::SUM_W-1:0]    total;
    logic [svs_pkg::SAMPLE_W-1:0] mean;
    logic [svs_pkg::PV_W-1:0]     pop_var;
    logic [svs_pkg::SD_W-1:0]     pop_sd;
    logic [svs_pkg::SV_W-1:0]     smp_var;
    logic [svs_pkg::SD_W-1:0]     smp_sd;
    logic                         undef;
    logic                         ovf;
  } run_stats_t;

  localparam int SAMPLE_MIN  = -(1 << (svs_pkg::SAMPLE_W - 1));
  localparam int SAMPLE_MAX  = (1 << (svs_pkg::SAMPLE_W - 1)) - 1;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 2000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [svs_pkg::SAMPLE_W-1:0] in_sample;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic [svs_pkg::CNT_W-1:0] out_count;
  logic signed [svs_pkg::SUM_W-1:0] out_total;
  logic signed [svs_pkg::SAMPLE_W-1:0] out_mean;
  logic [svs_pkg::PV_W-1:0] out_pop_variance;
  logic [svs_pkg::SD_W-1:0] out_pop_std_dev;
  logic [svs_pkg::SV_W-1:0] out_sample_variance;
  logic [svs_pkg::SD_W-1:0] out_sample_std_dev;
  logic out_sample_undefined;
  logic out_overflowed;

  // predictor state for the open run
  longint run_samples[$];
  bit run_dropped;
  run_stats_t pending_stats[$];
  int errors;
  bit quiet;
  int idle_cycles;
  int stall_left;

  sample_variance_stddev_unit DUT (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // fold one accepted request into the run, closing it on last
  function automatic void absorb_sample(longint s, bit last);
    run_stats_t st;
    longint total;
    longint avg;
    longint dev;
    longint unsigned sq_sum;
    longint unsigned pv;
    longint unsigned sv;
    longint n;
    if (run_samples.size() < svs_pkg::MAX_SAMPLES) run_samples.push_back(s);
    else run_dropped = 1'b1;
    if (!last) return;
    n = run_samples.size();
    total = 0;
    foreach (run_samples[i]) total += run_samples[i];
    avg = total / n;
    sq_sum = 0;
    foreach (run_samples[i]) begin
      dev = run_samples[i] - avg;
      sq_sum += longint'(dev * dev);
    end
    pv = sq_sum / n;
    sv = (n > 1) ? sq_sum / (n - 1) : 0;
    st.count   = svs_pkg::CNT_W'(n);
    st.total   = svs_pkg::SUM_W'(total);
    st.mean    = svs_pkg::SAMPLE_W'(avg);
    st.pop_var = svs_pkg::PV_W'(pv);
    st.pop_sd  = svs_pkg::SD_W'(isqrt(pv));
    st.smp_var = svs_pkg::SV_W'(sv);
    st.smp_sd  = (n > 1) ? svs_pkg::SD_W'(isqrt(sv)) : '0;
    st.undef   = (n == 1);
    st.ovf     = run_dropped;
    pending_stats.push_back(st);
    run_samples.delete();
    run_dropped = 1'b0;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // send one request, with an optional idle burst in front
  task automatic send_request(longint s, bit last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= svs_pkg::SAMPLE_W'(s);
    in_last   <= last;
    do @(posedge clk); while (in_stall);
    absorb_sample(s, last);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    in_last  <= 1'b0;
  endtask

  function automatic longint rand_sample();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 255)) - 128;
      1: return $signed($urandom_range(0, 65535)) - 32768;
      default: return longint'($signed($urandom_range(0, 32'hFFFFFF))) + SAMPLE_MIN;
    endcase
  endfunction

  // result check, output stall bursts and watchdog
  always @(posedge clk) begin
    run_stats_t exp_st;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sample_variance_stddev_unit regression: fail");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_stats.size() == 0) begin
          $error("result with no run pending");
          errors++;
        end else begin
          exp_st = pending_stats.pop_front();
          check_field("count", exp_st.count, out_count);
          check_field("total", exp_st.total, $unsigned(out_total));
          check_field("mean", exp_st.mean, $unsigned(out_mean));
          check_field("pop_variance", exp_st.pop_var, out_pop_variance);
          check_field("pop_std_dev", exp_st.pop_sd, out_pop_std_dev);
          check_field("sample_variance", exp_st.smp_var, out_sample_variance);
          check_field("sample_std_dev", exp_st.smp_sd, out_sample_std_dev);
          check_field("sample_undefined", exp_st.undef, out_sample_undefined);
          check_field("overflowed", exp_st.ovf, out_overflowed);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // extremes, single-sample, two-sample, three-sample and eight-sample runs
  task automatic test_directed();
    send_request(SAMPLE_MAX, 1'b1);
    send_request(SAMPLE_MIN, 1'b1);
    send_request(0, 1'b1);
    send_request(SAMPLE_MIN, 1'b0);
    send_request(SAMPLE_MAX, 1'b1);
    send_request(-1, 1'b0);
    send_request(2, 1'b1);
    for (int i = 0; i < 8; i++) send_request(i[0] ? SAMPLE_MAX : SAMPLE_MIN, i == 7);
    send_request(SAMPLE_MAX, 1'b0);
    send_request(SAMPLE_MAX, 1'b0);
    send_request(SAMPLE_MAX, 1'b1);
    send_request(-5, 1'b0);
    send_request(-4, 1'b0);
    send_request(3, 1'b1);
    release_input();
  endtask

  // full store, then dropped samples, including a dropped last
  task automatic test_store_full();
    for (int i = 0; i < svs_pkg::MAX_SAMPLES + 6; i++)
      send_request(rand_sample(), i == svs_pkg::MAX_SAMPLES + 5);
    release_input();
  endtask

  // random runs, mostly short, last stretch with no idling
  task automatic test_random_runs();
    int sent;
    int len;
    sent = 0;
    while (sent < 550) begin
      if (sent > 400) quiet = 1'b1;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 30);
      for (int i = 0; i < len; i++) send_request(rand_sample(), i == len - 1);
      sent += len;
    end
    release_input();
  endtask

  initial begin
    errors      = 0;
    quiet       = 1'b0;
    idle_cycles = 0;
    stall_left  = 0;
    run_dropped = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    in_last   <= 1'b0;
    out_stall <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random_runs();
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("sample_variance_stddev_unit regression: pass");
    end else begin
      $display("sample_variance_stddev_unit regression: fail");
    end
    $finish;
  end

endmodule
